### hw/rtl/pwds_pkg.sv
// ----------------------------------------------------------------------------
// pwds_pkg
// Shared types and constants for the pulse width distance sensor.
// ----------------------------------------------------------------------------
package pwds_pkg;

    localparam int TIME_W  = 16;
    localparam int WIDTH_W = 17;
    localparam int DIST_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COUNTER_TOP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NO_DETECT_WIDTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE    = 3'd5;

    // reset values of the configuration registers
    localparam logic [TIME_W-1:0]  COUNTER_TOP_RST     = 16'd65535;
    localparam logic [WIDTH_W-1:0] NO_DETECT_WIDTH_RST = 17'd2000;
    localparam logic [WIDTH_W-1:0] MIN_WIDTH_RST       = 17'd1000;
    localparam logic [WIDTH_W-1:0] MAX_WIDTH_RST       = 17'd1999;
    localparam logic [DIST_W-1:0]  MIN_DISTANCE_RST    = 16'd0;
    localparam logic [DIST_W-1:0]  MAX_DISTANCE_RST    = 16'd750;

    // high time that maps to zero distance
    localparam logic [WIDTH_W-1:0] WIDTH_OFFSET = 17'd1000;

    typedef enum logic [1:0] {
        ST_RISE      = 2'd0,
        ST_OK        = 2'd1,
        ST_NO_DETECT = 2'd2,
        ST_INVALID   = 2'd3
    } status_t;

    typedef struct packed {
        logic [TIME_W-1:0]  counter_top;
        logic [WIDTH_W-1:0] no_detect_width;
        logic [WIDTH_W-1:0] min_width;
        logic [WIDTH_W-1:0] max_width;
        logic [DIST_W-1:0]  min_distance;
        logic [DIST_W-1:0]  max_distance;
    } cfg_t;

    typedef struct packed {
        logic               awaiting_fall;
        logic [TIME_W-1:0]  rise_time;
        logic [DIST_W-1:0]  kept_distance;
    } state_t;

    typedef struct packed {
        status_t            status;
        logic [WIDTH_W-1:0] high_time;
    } res_t;

endpackage

### hw/rtl/pulse_width_distance_sensor.sv
// ----------------------------------------------------------------------------
// pulse_width_distance_sensor
// Input-capture pulse width measurement with distance conversion.
// ----------------------------------------------------------------------------
// Each input word is a captured counter value; words alternate rising and
// falling edges, starting with rising. Every word gives one result word. An
// edge passes an input register, then the combinational width/classify
// logic, and lands in the result register; the block takes one word per
// cycle as long as the result register drains. The sensor state
// (edge polarity, rise time, kept distance) is updated in the same cycle the
// result is registered, so consecutive words see each other's effect.
module pulse_width_distance_sensor
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               cfg_wr_en,
    input  logic [pwds_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pwds_pkg::CFG_DATA_W-1:0]    cfg_wdata,

    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [pwds_pkg::TIME_W-1:0]        edge_time,

    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         status,
    output logic [pwds_pkg::WIDTH_W-1:0]       high_time,
    output logic [pwds_pkg::DIST_W-1:0]        distance,
    output logic                               expect_falling
);

    pwds_pkg::cfg_t   cfg_reg;
    pwds_pkg::state_t state_reg;
    pwds_pkg::state_t state_next;
    pwds_pkg::res_t   res_next;

    logic                        in_vld_reg;
    logic [pwds_pkg::TIME_W-1:0] edge_reg;
    logic                        out_vld_reg;
    pwds_pkg::res_t              res_reg;
    logic [pwds_pkg::DIST_W-1:0] dist_reg;
    logic                        fall_reg;
    logic                        advance;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.counter_top     <= pwds_pkg::COUNTER_TOP_RST;
            cfg_reg.no_detect_width <= pwds_pkg::NO_DETECT_WIDTH_RST;
            cfg_reg.min_width       <= pwds_pkg::MIN_WIDTH_RST;
            cfg_reg.max_width       <= pwds_pkg::MAX_WIDTH_RST;
            cfg_reg.min_distance    <= pwds_pkg::MIN_DISTANCE_RST;
            cfg_reg.max_distance    <= pwds_pkg::MAX_DISTANCE_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                pwds_pkg::REG_COUNTER_TOP:
                    cfg_reg.counter_top <= cfg_wdata[pwds_pkg::TIME_W-1:0];
                pwds_pkg::REG_NO_DETECT_WIDTH:
                    cfg_reg.no_detect_width <= cfg_wdata[pwds_pkg::WIDTH_W-1:0];
                pwds_pkg::REG_MIN_WIDTH:
                    cfg_reg.min_width <= cfg_wdata[pwds_pkg::WIDTH_W-1:0];
                pwds_pkg::REG_MAX_WIDTH:
                    cfg_reg.max_width <= cfg_wdata[pwds_pkg::WIDTH_W-1:0];
                pwds_pkg::REG_MIN_DISTANCE:
                    cfg_reg.min_distance <= cfg_wdata[pwds_pkg::DIST_W-1:0];
                pwds_pkg::REG_MAX_DISTANCE:
                    cfg_reg.max_distance <= cfg_wdata[pwds_pkg::DIST_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // the word in the input register moves on unless a result is stuck
    assign advance  = in_vld_reg && !(out_vld_reg && out_stall);
    assign in_stall = in_vld_reg && out_vld_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            edge_reg <= edge_time;
        end
    end

    pwds_calc u_calc
    (
        .edge_time (edge_reg),
        .cfg       (cfg_reg),
        .cur       (state_reg),
        .nxt       (state_next),
        .res       (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg   <= state_next;
                out_vld_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg  <= res_next;
            dist_reg <= state_next.kept_distance;
            fall_reg <= state_next.awaiting_fall;
        end
    end

    assign out_valid      = out_vld_reg;
    assign status         = res_reg.status;
    assign high_time      = res_reg.high_time;
    assign distance       = dist_reg;
    assign expect_falling = fall_reg;

endmodule

### hw/rtl/pwds_calc.sv
// ----------------------------------------------------------------------------
// pwds_calc
// One edge step: high time with counter wrap, classification, distance and
// next sensor state.
// ----------------------------------------------------------------------------
module pwds_calc
(
    input  logic [pwds_pkg::TIME_W-1:0] edge_time,
    input  pwds_pkg::cfg_t              cfg,
    input  pwds_pkg::state_t            cur,
    output pwds_pkg::state_t            nxt,
    output pwds_pkg::res_t              res
);

    logic [pwds_pkg::WIDTH_W-1:0] width;
    logic [pwds_pkg::WIDTH_W-1:0] diff;
    logic [pwds_pkg::WIDTH_W+1:0] diff_x3;
    logic [pwds_pkg::WIDTH_W-1:0] dist_mm;
    logic                         dist_ok;

    // wrap path is taken modulo 2^17, like a plain 17-bit adder
    always_comb
    begin
        if (edge_time >= cur.rise_time)
        begin
            width = {1'b0, edge_time} - {1'b0, cur.rise_time};
        end
        else
        begin
            width = {1'b0, cfg.counter_top} + 17'd1 - {1'b0, cur.rise_time}
                    + {1'b0, edge_time};
        end
    end

    // (width - 1000) * 3 / 4, only used when width >= 1000
    assign diff    = width - pwds_pkg::WIDTH_OFFSET;
    assign diff_x3 = {2'b00, diff} + {1'b0, diff, 1'b0};
    assign dist_mm = diff_x3[pwds_pkg::WIDTH_W+1:2];
    assign dist_ok = (dist_mm >= {1'b0, cfg.min_distance})
                  && (dist_mm <= {1'b0, cfg.max_distance});

    always_comb
    begin
        nxt = cur;
        res.status    = pwds_pkg::ST_RISE;
        res.high_time = '0;
        if (!cur.awaiting_fall)
        begin
            nxt.rise_time     = edge_time;
            nxt.awaiting_fall = 1'b1;
        end
        else
        begin
            nxt.awaiting_fall = 1'b0;
            res.high_time     = width;
            if (width >= cfg.no_detect_width)
            begin
                res.status        = pwds_pkg::ST_NO_DETECT;
                nxt.kept_distance = '0;
            end
            else if (width < cfg.min_width || width > cfg.max_width
                     || width < pwds_pkg::WIDTH_OFFSET || !dist_ok)
            begin
                res.status = pwds_pkg::ST_INVALID;
            end
            else
            begin
                res.status        = pwds_pkg::ST_OK;
                nxt.kept_distance = dist_mm[pwds_pkg::DIST_W-1:0];
            end
        end
    end

endmodule

### hw/rtl/pwds_checker.sv
// ----------------------------------------------------------------------------
// pwds_checker
// Port-level checks for the pulse width distance sensor, bound to the top.
// ----------------------------------------------------------------------------
module pwds_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [1:0]                      status,
    input logic [pwds_pkg::WIDTH_W-1:0]    high_time,
    input logic [pwds_pkg::DIST_W-1:0]     distance,
    input logic                            expect_falling
);

    // a stalled word stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped while stalled");

    // only a rising edge leaves the block waiting for a fall
    a_polarity: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((status == pwds_pkg::ST_RISE) == expect_falling))
        else $error("edge polarity does not match status");

    a_rise_width: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == pwds_pkg::ST_RISE |-> high_time == '0)
        else $error("rising edge word carries a high time");

    a_no_detect: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == pwds_pkg::ST_NO_DETECT |-> distance == '0)
        else $error("no detection with nonzero distance");

endmodule

bind pulse_width_distance_sensor pwds_checker u_pwds_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .high_time      (high_time),
    .distance       (distance),
    .expect_falling (expect_falling)
);
